// ===== hdl/assert_macros.svh =====
// Assertion macros for the port-level checker file of this project.
// Depends on nothing; the using module must have signals named clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/isqn_pkg.sv =====
// Shared widths, constants and the controller state type of the square root block.
// Depends on nothing.
package isqn_pkg;

  localparam int WORD_W    = 32;
  localparam int ROOT_W    = 16;
  localparam int ITER_MAX  = 5;
  localparam int ITER_W    = $clog2(ITER_MAX + 1);
  localparam int LZ_W      = $clog2(WORD_W + 1);
  localparam int SHIFT_W   = LZ_W - 1;
  localparam int DIV_CNT_W = $clog2(WORD_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEED,
    ST_DIVIDE,
    ST_UPDATE
  } state_t;

endpackage

// ===== hdl/isqn_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on isqn_pkg.
module isqn_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [isqn_pkg::WORD_W-1:0]  dividend,
  input  logic [isqn_pkg::WORD_W-1:0]  divisor,
  output logic                         done,
  output logic [isqn_pkg::WORD_W-1:0]  quotient
);

  logic [isqn_pkg::WORD_W-1:0]    rem;
  logic [isqn_pkg::WORD_W-1:0]    quo;
  logic [isqn_pkg::WORD_W-1:0]    dvsr;
  logic [isqn_pkg::DIV_CNT_W-1:0] cnt;
  logic                           run;

  logic [isqn_pkg::WORD_W:0] rem_sh;
  logic [isqn_pkg::WORD_W:0] dvsr_ext;
  logic                      fits;

  // Bring down the next dividend bit and try the subtraction.
  assign rem_sh   = {rem, quo[isqn_pkg::WORD_W-1]};
  assign dvsr_ext = {1'b0, dvsr};
  assign fits     = (rem_sh >= dvsr_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvsr <= divisor;
      end else if (run) begin
        if (fits) begin
          rem <= isqn_pkg::WORD_W'(rem_sh - dvsr_ext);
        end else begin
          rem <= rem_sh[isqn_pkg::WORD_W-1:0];
        end
        quo <= {quo[isqn_pkg::WORD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == isqn_pkg::DIV_CNT_W'(isqn_pkg::WORD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== hdl/integer_square_root_newton.sv =====
// Top level of the integer square root block: seed search, Newton control and output.
// Depends on isqn_pkg and isqn_div.
//
//   channel   | handshake           | payload
//   ----------+---------------------+------------------------
//   command   | start, busy         | radicand[31:0]
//   result    | done (strobe)       | root[15:0]
//
// A beat is taken at a rising edge where start is high and busy is low.
// The leading-zero scan shifts the radicand one bit a cycle until its top bit is set or all bits are shifted out.
// Each Newton step runs the bit-serial divider (ST_DIVIDE) and then the update
// state (ST_UPDATE); busy stays high from the accepted beat until the controller
// is idle again, and done rises in the same cycle that busy falls.
// Reset (rst, synchronous) returns the controller to idle and drops done.
// The result is shown for exactly one cycle on done; the receiver cannot stall.
module integer_square_root_newton (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [isqn_pkg::WORD_W-1:0]  radicand,
  output logic                         busy,
  output logic                         done,
  output logic [isqn_pkg::ROOT_W-1:0]  root
);

  isqn_pkg::state_t state, state_next;

  // Working registers. The radicand copy is the dividend of every step,
  // scan is a shifted copy used to count leading zeros, cur is the iterate.
  logic [isqn_pkg::WORD_W-1:0]  a;
  logic [isqn_pkg::WORD_W-1:0]  scan;
  logic [isqn_pkg::LZ_W-1:0]    lz;
  logic [isqn_pkg::WORD_W-1:0]  cur;
  logic [isqn_pkg::ITER_W-1:0]  iter;

  logic                         div_go;
  logic                         div_done;
  logic [isqn_pkg::WORD_W-1:0]  div_q;
  logic [isqn_pkg::WORD_W-1:0]  divisor;

  logic                         scan_end;
  logic [isqn_pkg::LZ_W-1:0]    bits_used;
  logic [isqn_pkg::SHIFT_W-1:0] seed_sh;
  logic [isqn_pkg::WORD_W-1:0]  seed;
  logic [isqn_pkg::WORD_W:0]    sum;
  logic [isqn_pkg::WORD_W-1:0]  next_val;
  logic                         last;

  // The scan stops at the first set bit, or after all bits for a zero radicand.
  assign scan_end  = scan[isqn_pkg::WORD_W-1] || (lz == isqn_pkg::LZ_W'(isqn_pkg::WORD_W));

  // Seed is two to the power of half the significant bit count.
  assign bits_used = isqn_pkg::LZ_W'(isqn_pkg::WORD_W) - lz;
  assign seed_sh   = bits_used[isqn_pkg::LZ_W-1:1];
  assign seed      = isqn_pkg::WORD_W'(1) << seed_sh;

  // Newton update: (a / cur + cur) / 2, carried in one extra bit.
  assign sum      = {1'b0, div_q} + {1'b0, cur};
  assign next_val = sum[isqn_pkg::WORD_W:1];
  assign last     = (next_val == cur) || (next_val == '0)
                 || (iter == isqn_pkg::ITER_W'(isqn_pkg::ITER_MAX - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isqn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    divisor    = cur;
    case (state)
      isqn_pkg::ST_IDLE: begin
        if (start) begin
          state_next = isqn_pkg::ST_SCAN;
        end
      end
      isqn_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = isqn_pkg::ST_SEED;
        end
      end
      isqn_pkg::ST_SEED: begin
        // The divider latches the seed at the same edge that cur does.
        div_go     = 1'b1;
        divisor    = seed;
        state_next = isqn_pkg::ST_DIVIDE;
      end
      isqn_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = isqn_pkg::ST_UPDATE;
        end
      end
      isqn_pkg::ST_UPDATE: begin
        if (last) begin
          state_next = isqn_pkg::ST_IDLE;
        end else begin
          div_go     = 1'b1;
          divisor    = next_val;
          state_next = isqn_pkg::ST_DIVIDE;
        end
      end
      default: begin
        state_next = isqn_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath registers follow the controller state.
  always_ff @(posedge clk) begin
    case (state)
      isqn_pkg::ST_IDLE: begin
        if (start) begin
          a    <= radicand;
          scan <= radicand;
          lz   <= '0;
        end
      end
      isqn_pkg::ST_SCAN: begin
        if (!scan_end) begin
          scan <= {scan[isqn_pkg::WORD_W-2:0], 1'b0};
          lz   <= lz + 1'b1;
        end
      end
      isqn_pkg::ST_SEED: begin
        cur  <= seed;
        iter <= '0;
      end
      isqn_pkg::ST_UPDATE: begin
        cur  <= next_val;
        iter <= iter + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The root is the low half of the last iterate; done strobes it for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == isqn_pkg::ST_UPDATE) && last;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == isqn_pkg::ST_UPDATE) && last) begin
      root <= next_val[isqn_pkg::ROOT_W-1:0];
    end
  end

  assign busy = (state != isqn_pkg::ST_IDLE);

  isqn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (a),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

// ===== hdl/isqn_chk.sv =====
// Port-level checker for the square root block, bound to the top level.
// Depends on assert_macros.svh and integer_square_root_newton.
`include "assert_macros.svh"

module isqn_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result beat marks the end of an item, so the block is idle with it.
  `ASSERT_IMP(a_done_idle, done, !busy, "done while busy")

  // An accepted beat makes the block busy in the next cycle.
  `ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

  // An accepted beat never yields its result in the following cycle.
  `ASSERT_NXT(a_accept_no_done, start && !busy, !done, "result too early after accept")

  // The result strobe lasts a single cycle.
  `ASSERT_NXT(a_done_pulse, done, !done, "done held longer than one cycle")

  // Reset leaves the block idle with no result pending.
  `ASSERT_NXT_ALWAYS(a_reset_idle, rst, !busy && !done, "not idle after reset")

endmodule

bind integer_square_root_newton isqn_chk u_isqn_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== tb/isqn_checker.sv =====
// Checker for the integer square root block: watches the command and result channels,
// predicts each root by Newton iteration and compares it with what the block returns.
// Depends on isqn_pkg for widths and the iteration count.
module isqn_checker
  import isqn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [WORD_W-1:0] radicand,
  input  logic              done,
  input  logic [ROOT_W-1:0] root,
  output int unsigned       fails,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] radicand;
    logic [ROOT_W-1:0] root;
  } root_entry_t;

  root_entry_t pending_roots[$];

  // The seed is the power of two 2^(bit_length/2), where bit_length counts the
  // bits up to the highest set one (zero for a zero radicand). Each step forms
  // (a/cur + cur)/2 in 33 bits and stops on a fixed point or a zero iterate.
  function automatic logic [ROOT_W-1:0] newton_root_of(input logic [WORD_W-1:0] a);
    int unsigned       bit_length;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] nxt;
    logic [WORD_W:0]   sum;
    bit_length = 0;
    for (int b = 0; b < WORD_W; b++) begin
      if (a[b]) begin
        bit_length = b + 1;
      end
    end
    cur = {{(WORD_W-1){1'b0}}, 1'b1} << (bit_length >> 1);
    nxt = cur;
    for (int step = 0; step < ITER_MAX; step++) begin
      sum = {1'b0, a / cur} + {1'b0, cur};
      nxt = sum[WORD_W:1];
      if (nxt == cur || nxt == '0) begin
        break;
      end
      cur = nxt;
    end
    return nxt[ROOT_W-1:0];
  endfunction

  // Both counts start at zero as two-state variables.

  // Results are retired before new beats are queued, so a result that leaves
  // on the same edge as a new command beat still matches the older entry.
  always @(posedge clk) begin : watch
    root_entry_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_roots.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: unexpected result beat, root %0d", $realtime, root);
          end
          fails++;
        end else begin
          want = pending_roots.pop_front();
          if (root !== want.root) begin
            if (fails < 10) begin
              $display("%0t: radicand %h: root expected %0d, got %0d",
                       $realtime, want.radicand, want.root, root);
            end
            fails++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want.radicand = radicand;
        want.root = newton_root_of(radicand);
        pending_roots.push_back(want);
      end
      outstanding <= pending_roots.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the integer square root testbench: clock, reset, command stimulus and verdict.
// Depends on isqn_pkg, the block integer_square_root_newton and isqn_checker.
module testbench;
  import isqn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // A correct beat is bounded by the leading-zero scan plus at most five divider
  // steps, and the sender adds a random idle gap in front of each beat. For roughly
  // 830 beats the limit leaves ample headroom.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned RANDOM_BEATS = 800;

  logic              clk;
  logic              rst;
  logic              start;
  logic [WORD_W-1:0] radicand;
  logic              busy;
  logic              done;
  logic [ROOT_W-1:0] root;
  int unsigned       fails;
  int unsigned       outstanding;
  int unsigned       cycles;

  integer_square_root_newton i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .radicand (radicand),
    .busy     (busy),
    .done     (done),
    .root     (root)
  );

  isqn_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .radicand    (radicand),
    .done        (done),
    .root        (root),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here. The cycle
  // count starts at zero as a two-state variable.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Sends one command beat. The idle gap in front of it is drawn per beat, so
  // with a gap of zero start simply stays high from the previous beat and only
  // the radicand changes. busy is looked at on the falling edge, where it is
  // settled, and the beat is taken at the rising edge that follows.
  task automatic send_radicand(input logic [WORD_W-1:0] value);
    int unsigned gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    radicand <= value;
    do begin
      @(negedge clk);
    end while (busy !== 1'b0);
    @(posedge clk);
  endtask

  // A value near a perfect square: k*k - 1, k*k or k*k + 1, wrapping at 32 bits.
  function automatic logic [WORD_W-1:0] near_square(input logic [ROOT_W-1:0] k);
    logic [WORD_W-1:0] k_wide;
    k_wide = {{(WORD_W-ROOT_W){1'b0}}, k};
    return k_wide * k_wide + WORD_W'($urandom_range(0, 2)) - WORD_W'(1);
  endfunction

  initial begin : stimulus
    logic [WORD_W-1:0] value;
    rst      = 1'b1;
    start    = 1'b0;
    radicand = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Zero takes the seed of one straight to a zero iterate.
    // Small values exercise seeds of one and two. The top of the range starts
    // from a seed of 65536 and swings between 65535 and 65536, so the last
    // permitted step decides the root and a wide iterate would show only its
    // low 16 bits. Powers of two and their neighbours move the seed boundary.
    send_radicand(32'd0);
    send_radicand(32'd1);
    send_radicand(32'd2);
    send_radicand(32'd3);
    send_radicand(32'd4);
    send_radicand(32'd15);
    send_radicand(32'd16);
    send_radicand(32'd17);
    send_radicand(32'd255);
    send_radicand(32'h0000_FFFF);
    send_radicand(32'h0001_0000);
    send_radicand(32'h3FFF_FFFF);
    send_radicand(32'h4000_0000);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h8000_0000);
    send_radicand(32'hFFFE_0000);
    send_radicand(32'hFFFE_0001);
    send_radicand(32'hFFFF_0000);
    send_radicand(32'hFFFF_FFFE);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'hAAAA_AAAA);
    send_radicand(32'h5555_5555);

    // Random part. The mix spreads the bit length evenly, keeps full-width
    // values so that every radicand bit toggles, and hits the neighbourhood of
    // perfect squares where rounding of the iterate matters most.
    for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
      case ($urandom_range(0, 3))
        0: value = $urandom();
        1: value = $urandom() >> $urandom_range(0, WORD_W - 1);
        2: value = near_square(ROOT_W'($urandom()));
        default: value = $urandom_range(0, 1023);
      endcase
      send_radicand(value);
    end
    start <= 1'b0;

    // Drain: let the checker count the last beat, then wait for
    // every expected root and give the block time to show any stray result
    // beat before the verdict.
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== integer_square_root_newton.f =====
+incdir+hdl
hdl/isqn_pkg.sv
hdl/isqn_div.sv
hdl/integer_square_root_newton.sv
hdl/isqn_chk.sv
tb/isqn_checker.sv
tb/testbench.sv
